// ===== sv/lsd_pkg.sv =====
// ----------------------------------------------------------------------------
// lsd_pkg: shared constants and types
// Widths, depths and the cell control struct of the recency stack core.
// ----------------------------------------------------------------------------
package lsd_pkg;
    localparam int StackDepth = 64;
    localparam int RequestMax = 32;
    localparam int KeyW       = 64;
    localparam int DepthW     = $clog2(StackDepth + 1);
    localparam int ReqW       = $clog2(RequestMax + 1);
    localparam int ThrW       = 7;
    localparam int LimitW     = 7;
    localparam logic [ThrW-1:0] ThrSat = 7'd127;

    typedef logic [KeyW-1:0] t_key;

    typedef struct packed {
        logic shift;    // shift row toward the bottom by one, taking in from above
        logic lift;     // shift row toward the top by one, taking in from below
        logic clear;    // drop the cell's valid bit
    } t_cell_ctl;
endpackage

// ===== sv/lsd_if.sv =====
// ----------------------------------------------------------------------------
// lsd_in_if / lsd_out_if: valid/ready channels
// Input key channel and result channel of the recency stack core.
// ----------------------------------------------------------------------------
interface lsd_in_if;
    logic                  valid;
    logic                  ready;
    logic [63:0]           key_value;
    logic                  last_of_request;
    modport source (output valid, key_value, last_of_request, input ready);
    modport sink   (input valid, key_value, last_of_request, output ready);
endinterface

interface lsd_out_if;
    logic                  valid;
    logic                  ready;
    logic                  prefix_hit;
    logic [6:0]            threshold;
    logic                  request_end;
    logic                  overflow;
    modport source (output valid, prefix_hit, threshold, request_end, overflow,
                    input ready);
    modport sink   (input valid, prefix_hit, threshold, request_end, overflow,
                    output ready);
endinterface

// ===== sv/lsd_cell.sv =====
// ----------------------------------------------------------------------------
// lsd_cell: one entry of a shift chain
// Holds a key and a valid bit, compares against a broadcast key, shifts
// from either neighbor on command.
// ----------------------------------------------------------------------------
module lsd_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lsd_pkg::t_cell_ctl i_ctl,
    input  lsd_pkg::t_key      i_key_in,
    input  logic               i_vld_in,
    input  lsd_pkg::t_key      i_key_nxt,
    input  logic               i_vld_nxt,
    input  lsd_pkg::t_key      i_cmp_key,
    output lsd_pkg::t_key      o_key,
    output logic               o_vld,
    output logic               o_match
);
    import lsd_pkg::*;

    t_key r_key;
    logic r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctl.clear) begin
            r_vld <= 1'b0;
        end else if (i_ctl.shift) begin
            r_vld <= i_vld_in;
        end else if (i_ctl.lift) begin
            r_vld <= i_vld_nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_key <= i_key_in;
        end else if (i_ctl.lift) begin
            r_key <= i_key_nxt;
        end
    end

    assign o_key   = r_key;
    assign o_vld   = r_vld;
    assign o_match = r_vld && (r_key == i_cmp_key);
endmodule

// ===== sv/lru_stack_distance_hit_curve_core.sv =====
// ----------------------------------------------------------------------------
// lru_stack_distance_hit_curve_core: LRU stack distance and hit threshold
// Recency stack and request buffer as shift chains of compare cells.
// ----------------------------------------------------------------------------
// Usage:
//   in  (lsd_in_if.sink)   : one key per transaction, last_of_request marks
//                            the final key of a request.
//   out (lsd_out_if.source): one result per key: prefix_hit, threshold,
//                            request_end, overflow.
//   i_cfg_we/i_cfg_wdata   : tracked_limit, write only while idle.
// A key is looked up by parallel compare across all stack cells in the
// cycle it is accepted; its result is registered and offered the next
// cycle. Each ordinary key is accepted, then delivered, before the next is taken.
// The last key of a request starts a commit: the request buffer is rotated
// once, oldest first, pushing its distinct keys, up to the tracked limit,
// into a second cell chain; the old stack is then lifted out top first,
// pushing keys absent from the request while the limit allows; the new
// chain is then popped back into the stack.
// The input is held not ready during the commit and while a result waits.
// Reset empties the stack and request buffer and sets tracked_limit to 64.
// A stalled receiver holds the result register and blocks new input.
// ----------------------------------------------------------------------------
module lru_stack_distance_hit_curve_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [6:0] i_cfg_wdata,
    lsd_in_if.sink     in,
    lsd_out_if.source  out
);
    import lsd_pkg::*;

    localparam logic [1:0] StIdle = 2'd0;
    localparam logic [1:0] StReq  = 2'd1;
    localparam logic [1:0] StStk  = 2'd2;
    localparam logic [1:0] StCopy = 2'd3;
    localparam int ScanW = $clog2(StackDepth + 1);

    logic [LimitW-1:0] r_limit;
    logic [1:0]        r_st;
    logic [ReqW-1:0]   r_rcnt;
    logic [ThrW-1:0]   r_rmax, r_pthr;
    logic              r_cold;
    logic [DepthW-1:0] r_ncnt;
    logic [ScanW-1:0]  r_scan;
    logic              r_ovld;
    logic              r_hit, r_end, r_ovf;
    logic [ThrW-1:0]   r_thr;

    // stack chain, request chain, new stack chain
    t_key s_key [StackDepth];
    logic s_vld [StackDepth];
    logic s_m   [StackDepth];
    t_key q_key [RequestMax];
    logic q_vld [RequestMax];
    logic q_m   [RequestMax];
    t_key w_key [StackDepth];
    logic w_vld [StackDepth];
    logic w_m   [StackDepth];
    t_cell_ctl s_ctl, q_ctl, w_ctl;
    t_key      s_in, w_in, q_in, q_cmp, w_cmp;
    logic      q_vin;

    logic [DepthW-1:0] lim_eff;
    logic              acc;
    logic [DepthW-1:0] depth;
    logic              any_q, any_w, mv;
    logic [ThrW-1:0]   d7, n_rmax, nxt, n_thr;

    always_comb begin
        if (r_limit == '0 || {1'b0, r_limit} > 8'(StackDepth))
            lim_eff = DepthW'(StackDepth);
        else
            lim_eff = DepthW'(r_limit);
    end

    assign in.ready = (r_st == StIdle) && !r_ovld;
    assign acc      = in.valid && in.ready;

    // priority encode the hit depth
    always_comb begin
        depth = '0;
        for (int i = StackDepth - 1; i >= 0; i--) begin
            if (s_m[i]) depth = DepthW'(i + 1);
        end
    end

    always_comb begin
        any_q = 1'b0;
        any_w = 1'b0;
        for (int i = 0; i < RequestMax; i++) any_q = any_q | q_m[i];
        for (int i = 0; i < StackDepth; i++) any_w = any_w | w_m[i];
    end

    // commit phase: the request chain rotates out of its bottom cell, oldest entry first
    assign q_cmp = (r_st == StStk) ? s_key[0] : in.key_value;
    assign w_cmp = (r_st == StReq) ? q_key[RequestMax-1] : '0;
    assign s_in  = w_key[0];
    assign w_in  = (r_st == StReq) ? q_key[RequestMax-1] : s_key[0];
    assign q_in  = (r_st == StReq) ? q_key[RequestMax-1] : in.key_value;
    assign q_vin = (r_st == StReq) ? q_vld[RequestMax-1] : 1'b1;

    always_comb begin
        mv = 1'b0;
        unique case (r_st)
            StReq:  mv = q_vld[RequestMax-1] && !any_w && (r_ncnt < lim_eff);
            StStk:  mv = s_vld[0] && !any_q && (r_ncnt < lim_eff);
            default: mv = 1'b0;
        endcase
    end

    always_comb begin
        s_ctl = '0;
        q_ctl = '0;
        w_ctl = '0;
        unique case (r_st)
            StIdle: q_ctl.shift = acc && (r_rcnt < ReqW'(RequestMax));
            StReq: begin
                q_ctl.shift = 1'b1;
                w_ctl.shift = mv;
            end
            StStk: begin
                s_ctl.lift  = 1'b1;
                w_ctl.shift = mv;
            end
            StCopy: begin
                s_ctl.shift = w_vld[0];
                w_ctl.lift  = w_vld[0];
                q_ctl.clear = 1'b1;
            end
        endcase
    end

    for (genvar g = 0; g < StackDepth; g++) begin : g_stk
        lsd_cell u_s (
            .i_clk, .i_rst_n, .i_ctl(s_ctl),
            .i_key_in(g == 0 ? s_in : s_key[(g == 0) ? 0 : g - 1]),
            .i_vld_in(g == 0 ? (r_st == StCopy && w_vld[0])
                             : s_vld[(g == 0) ? 0 : g - 1]),
            .i_key_nxt(g == StackDepth - 1 ? '0
                                           : s_key[(g == StackDepth - 1) ? g : g + 1]),
            .i_vld_nxt(g == StackDepth - 1 ? 1'b0
                                           : s_vld[(g == StackDepth - 1) ? g : g + 1]),
            .i_cmp_key(in.key_value),
            .o_key(s_key[g]), .o_vld(s_vld[g]), .o_match(s_m[g]));
        lsd_cell u_w (
            .i_clk, .i_rst_n, .i_ctl(w_ctl),
            .i_key_in(g == 0 ? w_in : w_key[(g == 0) ? 0 : g - 1]),
            .i_vld_in(g == 0 ? (r_st != StCopy) : w_vld[(g == 0) ? 0 : g - 1]),
            .i_key_nxt(g == StackDepth - 1 ? '0
                                           : w_key[(g == StackDepth - 1) ? g : g + 1]),
            .i_vld_nxt(g == StackDepth - 1 ? 1'b0
                                           : w_vld[(g == StackDepth - 1) ? g : g + 1]),
            .i_cmp_key(w_cmp),
            .o_key(w_key[g]), .o_vld(w_vld[g]), .o_match(w_m[g]));
    end

    for (genvar g = 0; g < RequestMax; g++) begin : g_req
        lsd_cell u_q (
            .i_clk, .i_rst_n, .i_ctl(q_ctl),
            .i_key_in(g == 0 ? q_in : q_key[(g == 0) ? 0 : g - 1]),
            .i_vld_in(g == 0 ? q_vin : q_vld[(g == 0) ? 0 : g - 1]),
            .i_key_nxt(g == RequestMax - 1 ? '0
                                           : q_key[(g == RequestMax - 1) ? g : g + 1]),
            .i_vld_nxt(g == RequestMax - 1 ? 1'b0
                                           : q_vld[(g == RequestMax - 1) ? g : g + 1]),
            .i_cmp_key(q_cmp),
            .o_key(q_key[g]), .o_vld(q_vld[g]), .o_match(q_m[g]));
    end

    // threshold
    always_comb begin
        d7     = ThrW'(depth);
        n_rmax = (d7 > r_rmax) ? d7 : r_rmax;
        nxt    = (r_pthr == ThrSat) ? ThrSat : r_pthr + 1'b1;
        n_thr  = (n_rmax > nxt) ? n_rmax : nxt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= 7'd64;
            r_st    <= StIdle;
            r_rcnt  <= '0;
            r_rmax  <= '0;
            r_pthr  <= '0;
            r_cold  <= 1'b0;
            r_ncnt  <= '0;
            r_scan  <= '0;
            r_ovld  <= 1'b0;
        end else begin
            if (i_cfg_we) r_limit <= i_cfg_wdata;
            if (out.valid && out.ready) r_ovld <= 1'b0;
            unique case (r_st)
                StIdle: begin
                    if (acc) begin
                        r_ovld <= 1'b1;
                        if (r_rcnt < ReqW'(RequestMax)) r_rcnt <= r_rcnt + 1'b1;
                        if (r_cold || depth == '0) begin
                            r_cold <= 1'b1;
                        end else begin
                            r_rmax <= n_rmax;
                            r_pthr <= n_thr;
                        end
                        if (in.last_of_request) begin
                            r_st   <= StReq;
                            r_scan <= '0;
                            r_ncnt <= '0;
                        end
                    end
                end
                StReq: begin
                    // rotate the request chain once fully, oldest first
                    if (mv) r_ncnt <= r_ncnt + 1'b1;
                    if (r_scan == ScanW'(RequestMax - 1)) begin
                        r_st   <= StStk;
                        r_scan <= '0;
                    end else begin
                        r_scan <= r_scan + 1'b1;
                    end
                end
                StStk: begin
                    if (mv) r_ncnt <= r_ncnt + 1'b1;
                    if (r_scan == ScanW'(StackDepth - 1)) begin
                        r_st   <= StCopy;
                        r_scan <= '0;
                    end else begin
                        r_scan <= r_scan + 1'b1;
                    end
                end
                StCopy: begin
                    if (!w_vld[0]) begin
                        r_st   <= StIdle;
                        r_rcnt <= '0;
                        r_rmax <= '0;
                        r_pthr <= '0;
                        r_cold <= 1'b0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_hit <= !(r_cold || depth == '0);
            r_thr <= (r_cold || depth == '0) ? '0 : n_thr;
            r_end <= in.last_of_request;
            r_ovf <= !(r_rcnt < ReqW'(RequestMax));
        end
    end

    assign out.valid       = r_ovld;
    assign out.prefix_hit  = r_hit;
    assign out.threshold   = r_thr;
    assign out.request_end = r_end;
    assign out.overflow    = r_ovf;
endmodule

// ===== tb/sv/lru_stack_distance_hit_curve_core_tb.sv =====
// ----------------------------------------------------------------------------
// lru_stack_distance_hit_curve_core_tb: self-checking recency stack bench
// Drives requests of 64-bit keys with bursty valid and a stalling receiver.
// It predicts depth, threshold and overflow per key from its own LRU stack,
// and it reprograms tracked_limit between phases, including the extremes.
// ----------------------------------------------------------------------------
module lru_stack_distance_hit_curve_core_tb;
    import lsd_pkg::*;

    localparam int CommitCycles = RequestMax + 2 * StackDepth + 40;

    typedef struct {
        logic           hit;
        logic [ThrW-1:0] thr;
        logic           req_end;
        logic           ovf;
    } t_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [LimitW-1:0] i_cfg_wdata;

    lsd_in_if  in_ch();
    lsd_out_if out_ch();

    lru_stack_distance_hit_curve_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .in          (in_ch.sink),
        .out         (out_ch.source)
    );

    // model state
    t_key            lru_stack[$];
    t_key            req_buf[$];
    int              run_max;
    int              prev_thr;
    bit              cold;
    logic [LimitW-1:0] limit_reg;
    t_result         pending_results[$];

    int errors;
    int n_items, n_requests, n_hits, n_ovf, n_checked;
    int burst_left, gap_max, stall_pct, hold_req;
    t_key key_pool[100];

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #40000000;
        $display("FAIL lru_stack_distance_hit_curve_core");
        $finish;
    end

    task automatic report(input string what, input int got, input int want);
        errors++;
        $display("mismatch %0s: got %0d expected %0d (result %0d)", what, got, want,
                 n_checked);
    endtask

    function automatic int effective_limit();
        if (limit_reg == 0 || limit_reg > StackDepth) return StackDepth;
        return limit_reg;
    endfunction

    function automatic void commit_stack();
        t_key next_stack[$];
        int lim;
        lim = effective_limit();
        foreach (req_buf[i]) begin
            if (next_stack.size() < lim) begin
                if (!(req_buf[i] inside {next_stack})) next_stack = {next_stack, req_buf[i]};
            end
        end
        foreach (lru_stack[i]) begin
            if (next_stack.size() < lim && !(lru_stack[i] inside {req_buf}))
                next_stack = {next_stack, lru_stack[i]};
        end
        lru_stack = next_stack;
    endfunction

    function automatic void predict_result(input t_key key, input bit last);
        t_result r;
        int depth;
        int thr;
        depth = 0;
        foreach (lru_stack[i]) begin
            if (depth == 0 && lru_stack[i] == key) depth = i + 1;
        end
        thr = 0;
        if (cold || depth == 0) begin
            cold = 1'b1;
            r.hit = 1'b0;
        end else begin
            if (depth > run_max) run_max = depth;
            thr = (run_max > prev_thr + 1) ? run_max : prev_thr + 1;
            if (thr > ThrSat) thr = ThrSat;
            prev_thr = thr;
            r.hit = 1'b1;
            n_hits++;
        end
        r.ovf = req_buf.size() >= RequestMax;
        if (!r.ovf) req_buf = {req_buf, key};
        else n_ovf++;
        r.thr = thr[ThrW-1:0];
        r.req_end = last;
        if (last) begin
            commit_stack();
            req_buf.delete();
            run_max = 0;
            prev_thr = 0;
            cold = 1'b0;
            n_requests++;
        end
        pending_results = {pending_results, r};
    endfunction

    task automatic send_key(input t_key key, input bit last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_ch.valid           <= 1'b1;
        in_ch.key_value       <= key;
        in_ch.last_of_request <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_result(key, last);
        n_items++;
    endtask

    task automatic end_stream();
        in_ch.valid <= 1'b0;
    endtask

    task automatic wait_idle();
        end_stream();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (CommitCycles) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [LimitW-1:0] value);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        limit_reg = value;
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_key pick_key();
        if ($urandom_range(99) < 10) return {$urandom, $urandom};
        return key_pool[$urandom_range(0, 99)];
    endfunction

    task automatic send_request(input int len);
        for (int i = 0; i < len; i++) send_key(pick_key(), i == len - 1);
    endtask

    // extreme keys, a cold start, duplicates and re-hits
    task automatic test_directed();
        send_key('0, 1'b0);
        send_key('1, 1'b0);
        send_key(64'h8000_0000_0000_0000, 1'b0);
        send_key(64'h7fff_ffff_ffff_ffff, 1'b1);
        send_key('1, 1'b1);
        send_key(64'h7fff_ffff_ffff_ffff, 1'b0);
        send_key('0, 1'b0);
        send_key('0, 1'b0);
        send_key(64'h8000_0000_0000_0000, 1'b1);
        send_key('0, 1'b0);
        send_key(64'h1234, 1'b0);
        send_key('1, 1'b1);
    endtask

    // full request buffer, and one long all-hit request that saturates
    task automatic test_overflow_saturation();
        for (int i = 0; i < 40; i++) send_key(key_pool[i % 36], i == 39);
        for (int i = 0; i < 140; i++) send_key(key_pool[0], i == 139);
    endtask

    // full stack, then lower the limit and look deep before the next commit
    task automatic test_limits();
        for (int i = 0; i < 64; i++) send_key(key_pool[i], i % 8 == 7);
        write_limit(7'd4);
        send_key(key_pool[0], 1'b0);
        send_key(key_pool[60], 1'b1);
        send_key(key_pool[5], 1'b1);
        write_limit(7'd1);
        send_request(5);
        send_request(3);
        write_limit(7'd0);
        send_request(20);
        write_limit(7'd127);
        send_request(20);
    endtask

    // long receiver hold-off while the sender keeps offering
    task automatic test_backpressure();
        gap_max  = 0;
        hold_req = 300;
        send_request(12);
        send_request(6);
    endtask

    task automatic test_random(input int count);
        logic [LimitW-1:0] limits[6];
        int start;
        limits = '{7'd64, 7'd1, 7'd17, 7'd0, 7'd127, 7'd64};
        for (int p = 0; p < 6; p++) begin
            write_limit(p == 2 ? 7'($urandom_range(2, 63)) : limits[p]);
            gap_max   = (p % 3 == 0) ? 0 : $urandom_range(1, 6);
            stall_pct = (p % 2 == 0) ? 0 : $urandom_range(10, 70);
            start = n_items;
            while (n_items - start < count / 6)
                send_request($urandom_range(99) < 8 ? $urandom_range(30, 40)
                                                   : $urandom_range(1, 10));
        end
    endtask

    // receiver: stall pattern, hold-off and result check
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (pending_results.size() == 0) begin
                    report("unexpected result", 1, 0);
                end else begin
                    want = pending_results.pop_front();
                    if (out_ch.prefix_hit !== want.hit)
                        report("prefix_hit", out_ch.prefix_hit, want.hit);
                    if (out_ch.threshold !== want.thr)
                        report("threshold", out_ch.threshold, want.thr);
                    if (out_ch.request_end !== want.req_end)
                        report("request_end", out_ch.request_end, want.req_end);
                    if (out_ch.overflow !== want.ovf)
                        report("overflow", out_ch.overflow, want.ovf);
                end
                n_checked++;
            end
            if (hold_req > 0) begin
                out_ch.ready <= 1'b0;
                hold_req--;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    initial begin
        in_ch.valid           <= 1'b0;
        in_ch.key_value       <= '0;
        in_ch.last_of_request <= 1'b0;
        i_cfg_we              <= 1'b0;
        i_cfg_wdata           <= '0;
        i_rst_n               <= 1'b0;
        limit_reg = 7'd64;
        gap_max = 3;
        stall_pct = 25;
        for (int i = 0; i < 100; i++) key_pool[i] = {$urandom, $urandom};
        key_pool[96] = '0;
        key_pool[97] = '1;
        key_pool[98] = 64'h8000_0000_0000_0000;
        key_pool[99] = 64'h7fff_ffff_ffff_ffff;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_overflow_saturation();
        test_limits();
        test_backpressure();
        test_random(1700);
        wait_idle();

        $display("covered %0d keys in %0d requests: %0d hits, %0d overflowed keys",
                 n_items, n_requests, n_hits, n_ovf);
        $display("limits 0, 1, 4, 64, 127 and a random one; %0d results checked",
                 n_checked);
        if (errors == 0) begin
            $display("PASS lru_stack_distance_hit_curve_core");
        end else begin
            $display("FAIL lru_stack_distance_hit_curve_core");
        end
        $finish;
    end
endmodule
